[hw/rtl/gate_list_circuit_evaluator_top_macros.svh]
// ----------------------------------------------------------------------------
// Gate list evaluator assertion macros
// Concurrent assertion helpers shared by the evaluator RTL; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef GATE_LIST_CIRCUIT_EVALUATOR_TOP_MACROS_SVH
`define GATE_LIST_CIRCUIT_EVALUATOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define GLE_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gle assertion failed");
// next-cycle implication
`define GLE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gle assertion failed");
`else
`define GLE_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define GLE_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

[hw/rtl/gle_pkg.sv]
// ----------------------------------------------------------------------------
// Gate list evaluator package
// Command and status codes, field widths and the issue-to-evaluate record.
// ----------------------------------------------------------------------------
package gle_pkg;

   localparam int unsigned WIRE_CAPACITY_DEF = 4096;
   localparam int unsigned WIRE_NUM_W        = 12;
   localparam int unsigned TT_W              = 4;

   typedef enum logic [1:0] {
      CMD_RESTART = 2'd0,
      CMD_INPUT   = 2'd1,
      CMD_GATE    = 2'd2,
      CMD_OUTPUT  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_BAD_ARITY = 2'd1,
      ST_UNWRITTEN = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   // how the evaluate stage forms the result bit
   typedef enum logic [2:0] {
      SEL_ZERO,
      SEL_VALUE,
      SEL_GATE1,
      SEL_GATE2,
      SEL_WIRE
   } sel_type;

   typedef struct packed {
      sel_type                 sel;
      logic                    value;
      logic [TT_W-1:0]         tt;
      logic                    wr_en;
      status_type              status;
      logic [WIRE_NUM_W-1:0]   wire_number;
   } stage_type;

endpackage

[hw/rtl/gle_chan_if.sv]
// ----------------------------------------------------------------------------
// Gate list evaluator channels
// Valid/ready request and response channels with their payloads.
// ----------------------------------------------------------------------------
interface gle_req_if;
   logic                                valid;
   logic                                ready;
   logic [1:0]                          cmd;
   logic                                value;
   logic [1:0]                          arity;
   logic [gle_pkg::WIRE_NUM_W-1:0]      first_wire;
   logic [gle_pkg::WIRE_NUM_W-1:0]      second_wire;
   logic [gle_pkg::TT_W-1:0]            truth_table;

   modport source (output valid, cmd, value, arity, first_wire, second_wire, truth_table,
                   input ready);
   modport sink   (input valid, cmd, value, arity, first_wire, second_wire, truth_table,
                   output ready);
endinterface

interface gle_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                result_bit;
   logic [gle_pkg::WIRE_NUM_W-1:0]      wire_number;
   logic [1:0]                          status;

   modport source (output valid, result_bit, wire_number, status, input ready);
   modport sink   (input valid, result_bit, wire_number, status, output ready);
endinterface

[hw/rtl/gle_ram.sv]
// ----------------------------------------------------------------------------
// Gate list evaluator RAM
// Single-port-write, single-port-read RAM; read data registered, old data on
// a same-address collision.
// ----------------------------------------------------------------------------
module gle_ram #(
   parameter int unsigned WIDTH = 1,
   parameter int unsigned DEPTH = gle_pkg::WIRE_CAPACITY_DEF,
   localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/gle_issue.sv]
// ----------------------------------------------------------------------------
// Gate list evaluator issue stage
// Takes request beats, keeps the wire count, decides status and issues reads.
// ----------------------------------------------------------------------------
`include "gate_list_circuit_evaluator_top_macros.svh"

module gle_issue #(
   parameter int unsigned WIRE_CAPACITY = gle_pkg::WIRE_CAPACITY_DEF,
   localparam int unsigned AW    = $clog2(WIRE_CAPACITY),
   localparam int unsigned CNT_W = $clog2(WIRE_CAPACITY + 1)
) (
   input  logic                clock,
   input  logic                reset,
   gle_req_if.sink             req,
   input  logic                advance,
   output logic                s1_valid,
   output gle_pkg::stage_type  s1_ctrl,
   output logic [AW-1:0]       s1_addr1,
   output logic [AW-1:0]       s1_addr2,
   output logic [AW-1:0]       s1_waddr,
   output logic                rd_en,
   output logic [AW-1:0]       rd_addr1,
   output logic [AW-1:0]       rd_addr2
);

   logic [CNT_W-1:0]    count_ff, count_in;
   logic                s1_valid_ff, s1_valid_in;
   gle_pkg::stage_type  ctrl_ff, ctrl_in;
   logic [AW-1:0]       addr1_ff, addr2_ff, waddr_ff;
   logic                fire;
   logic                full;
   logic                written1, written2;
   logic [31:0]         w1_wide, w2_wide, cnt_wide;

   assign req.ready = !s1_valid_ff || advance;
   assign fire      = req.valid && req.ready;

   assign w1_wide   = 32'(req.first_wire);
   assign w2_wide   = 32'(req.second_wire);
   assign cnt_wide  = 32'(count_ff);
   assign full      = cnt_wide >= 32'(WIRE_CAPACITY);
   assign written1  = w1_wide < cnt_wide;
   assign written2  = w2_wide < cnt_wide;

   assign rd_en     = fire;
   assign rd_addr1  = w1_wide[AW-1:0];
   assign rd_addr2  = w2_wide[AW-1:0];

   always_comb begin
      ctrl_in             = '0;
      ctrl_in.sel         = gle_pkg::SEL_ZERO;
      ctrl_in.status      = gle_pkg::ST_OK;
      ctrl_in.value       = req.value;
      ctrl_in.tt          = req.truth_table;
      count_in            = count_ff;
      unique case (gle_pkg::cmd_type'(req.cmd))
         gle_pkg::CMD_RESTART: begin
            count_in = '0;
         end
         gle_pkg::CMD_OUTPUT: begin
            ctrl_in.wire_number = req.first_wire;
            if (written1) begin
               ctrl_in.sel = gle_pkg::SEL_WIRE;
            end else begin
               ctrl_in.status = gle_pkg::ST_UNWRITTEN;
            end
         end
         gle_pkg::CMD_INPUT, gle_pkg::CMD_GATE: begin
            if (full) begin
               ctrl_in.status = gle_pkg::ST_FULL;
            end else begin
               ctrl_in.wr_en       = 1'b1;
               ctrl_in.wire_number = cnt_wide[gle_pkg::WIRE_NUM_W-1:0];
               count_in            = CNT_W'(count_ff + CNT_W'(1));
               if (req.cmd == gle_pkg::CMD_INPUT) begin
                  ctrl_in.sel = gle_pkg::SEL_VALUE;
               end else if (req.arity != 2'd1 && req.arity != 2'd2) begin
                  ctrl_in.status = gle_pkg::ST_BAD_ARITY;
               end else if (!written1 || (req.arity == 2'd2 && !written2)) begin
                  ctrl_in.status = gle_pkg::ST_UNWRITTEN;
               end else if (req.arity == 2'd2) begin
                  ctrl_in.sel = gle_pkg::SEL_GATE2;
               end else begin
                  ctrl_in.sel = gle_pkg::SEL_GATE1;
               end
            end
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (fire) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (fire) begin
            count_ff <= count_in;
         end
      end
   end

   // payload of the stage register: load on every accepted beat
   always_ff @(posedge clock) begin
      if (fire) begin
         ctrl_ff  <= ctrl_in;
         addr1_ff <= rd_addr1;
         addr2_ff <= rd_addr2;
         waddr_ff <= cnt_wide[AW-1:0];
      end
   end

   assign s1_valid = s1_valid_ff;
   assign s1_ctrl  = ctrl_ff;
   assign s1_addr1 = addr1_ff;
   assign s1_addr2 = addr2_ff;
   assign s1_waddr = waddr_ff;

   `GLE_ASSERT_NOW(a_count_cap, clock, reset, 1'b1, 32'(count_ff) <= 32'(WIRE_CAPACITY))
   `GLE_ASSERT_NEXT(a_restart_clears, clock, reset,
      fire && req.cmd == gle_pkg::CMD_RESTART, count_ff == '0)
   `GLE_ASSERT_NEXT(a_stage_holds, clock, reset, s1_valid_ff && !advance, s1_valid_ff)

endmodule

[hw/rtl/gle_eval.sv]
// ----------------------------------------------------------------------------
// Gate list evaluator evaluate stage
// Forwards the last write, applies the truth table, writes back and holds
// the response register.
// ----------------------------------------------------------------------------
`include "gate_list_circuit_evaluator_top_macros.svh"

module gle_eval #(
   parameter int unsigned WIRE_CAPACITY = gle_pkg::WIRE_CAPACITY_DEF,
   localparam int unsigned AW = $clog2(WIRE_CAPACITY)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                s1_valid,
   input  gle_pkg::stage_type  s1_ctrl,
   input  logic [AW-1:0]       s1_addr1,
   input  logic [AW-1:0]       s1_addr2,
   input  logic [AW-1:0]       s1_waddr,
   input  logic                rd_data1,
   input  logic                rd_data2,
   output logic                advance,
   output logic                wr_en,
   output logic [AW-1:0]       wr_addr,
   output logic                wr_data,
   gle_rsp_if.source           rsp
);

   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_bit_ff;
   logic [gle_pkg::WIRE_NUM_W-1:0] rsp_wire_ff;
   gle_pkg::status_type            rsp_status_ff;
   logic                           lw_valid_ff, lw_valid_in;
   logic [AW-1:0]                  lw_addr_ff;
   logic                           lw_data_ff;
   logic                           bit_a, bit_b, result;
   logic                           move;

   assign advance = !rsp_valid_ff || rsp.ready;
   assign move    = s1_valid && advance;

   // the RAM read may have raced the previous write: take the latest write
   assign bit_a = (lw_valid_ff && lw_addr_ff == s1_addr1) ? lw_data_ff : rd_data1;
   assign bit_b = (lw_valid_ff && lw_addr_ff == s1_addr2) ? lw_data_ff : rd_data2;

   always_comb begin
      unique case (s1_ctrl.sel)
         gle_pkg::SEL_VALUE: result = s1_ctrl.value;
         gle_pkg::SEL_GATE1: result = s1_ctrl.tt[{1'b0, bit_a}];
         gle_pkg::SEL_GATE2: result = s1_ctrl.tt[{bit_a, bit_b}];
         gle_pkg::SEL_WIRE:  result = bit_a;
         default:            result = 1'b0;
      endcase
   end

   assign wr_en   = move && s1_ctrl.wr_en;
   assign wr_addr = s1_waddr;
   assign wr_data = result;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      lw_valid_in = lw_valid_ff || wr_en;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         lw_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         lw_valid_ff  <= lw_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         rsp_bit_ff    <= result;
         rsp_wire_ff   <= s1_ctrl.wire_number;
         rsp_status_ff <= s1_ctrl.status;
      end
      if (wr_en) begin
         lw_addr_ff <= s1_waddr;
         lw_data_ff <= result;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.result_bit  = rsp_bit_ff;
   assign rsp.wire_number = rsp_wire_ff;
   assign rsp.status      = rsp_status_ff;

   `GLE_ASSERT_NEXT(a_gate_ok, clock, reset,
      move && s1_ctrl.sel == gle_pkg::SEL_GATE2, rsp_valid_ff && rsp_status_ff == gle_pkg::ST_OK)
   `GLE_ASSERT_NEXT(a_stall_keeps_rsp, clock, reset, s1_valid && !advance, rsp_valid_ff)
   `GLE_ASSERT_NEXT(a_fwd_tracks_write, clock, reset, wr_en,
      lw_valid_ff && lw_addr_ff == $past(s1_waddr))

endmodule

[hw/rtl/gate_list_circuit_evaluator_top.sv]
// ----------------------------------------------------------------------------
// Gate list circuit evaluator
// Usage:
//   req carries one gate list line per beat (restart, primary input, gate,
//   output read); rsp returns exactly one beat per request, in order.
//   Both channels are valid/ready; a beat moves when valid and ready are high.
//   Path: an accepted request is loaded into the issue stage register, then
//   into the response register, from which its response beat moves.
//   Throughput: one item per cycle while rsp does not stall, set by the wire
//   store read in the issue stage and the write-back in the evaluate stage;
//   a write that a following read races is forwarded from a last-write register.
//   The wire store is two 1-bit RAMs of WIRE_CAPACITY entries written in step,
//   one per gate input port. Appends follow the wire count; reads beyond the
//   count are flagged and never reach the stored data, so no clearing pass runs.
//   Reset (synchronous) empties the pipeline and sets the wire count to zero;
//   req.ready is high in the first cycle after reset.
//   When rsp stalls the response register holds, the item behind it holds in
//   the issue stage, and req.ready stays low from then until rsp.ready returns.
// ----------------------------------------------------------------------------
module gate_list_circuit_evaluator_top #(
   parameter int unsigned WIRE_CAPACITY = gle_pkg::WIRE_CAPACITY_DEF
) (
   input  logic        clock,
   input  logic        reset,
   gle_req_if.sink     req,
   gle_rsp_if.source   rsp
);

   localparam int unsigned AW = $clog2(WIRE_CAPACITY);

   gle_pkg::stage_type s1_ctrl;
   logic               s1_valid;
   logic               advance;
   logic [AW-1:0]      s1_addr1, s1_addr2, s1_waddr;
   logic               rd_en;
   logic [AW-1:0]      rd_addr1, rd_addr2;
   logic               rd_data1, rd_data2;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic               wr_data;

   gle_issue #(.WIRE_CAPACITY(WIRE_CAPACITY)) u_issue (
      .clock    (clock),
      .reset    (reset),
      .req      (req),
      .advance  (advance),
      .s1_valid (s1_valid),
      .s1_ctrl  (s1_ctrl),
      .s1_addr1 (s1_addr1),
      .s1_addr2 (s1_addr2),
      .s1_waddr (s1_waddr),
      .rd_en    (rd_en),
      .rd_addr1 (rd_addr1),
      .rd_addr2 (rd_addr2)
   );

   gle_ram #(.WIDTH(1), .DEPTH(WIRE_CAPACITY)) u_store_a (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr1),
      .rd_data (rd_data1)
   );

   gle_ram #(.WIDTH(1), .DEPTH(WIRE_CAPACITY)) u_store_b (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr2),
      .rd_data (rd_data2)
   );

   gle_eval #(.WIRE_CAPACITY(WIRE_CAPACITY)) u_eval (
      .clock    (clock),
      .reset    (reset),
      .s1_valid (s1_valid),
      .s1_ctrl  (s1_ctrl),
      .s1_addr1 (s1_addr1),
      .s1_addr2 (s1_addr2),
      .s1_waddr (s1_waddr),
      .rd_data1 (rd_data1),
      .rd_data2 (rd_data2),
      .advance  (advance),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rsp      (rsp)
   );

endmodule

[tb/netlist_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Gate list evaluator checker
// Watches the request and response channels, keeps its own wire store and
// wire count, works out the response of every request beat and compares each
// response beat field by field with the oldest one still waiting.
// ----------------------------------------------------------------------------
module netlist_checker (
   input  logic        clock,
   input  logic        reset,
   gle_req_if          req,
   gle_rsp_if          rsp,
   output int unsigned mismatches,
   output int unsigned outstanding
);
   import gle_pkg::*;

   localparam int unsigned CAPACITY = WIRE_CAPACITY_DEF;

   typedef struct packed {
      logic                  result_bit;
      logic [WIRE_NUM_W-1:0] wire_number;
      status_type            status;
   } wire_result_type;

   logic            wire_bits [0:CAPACITY-1];
   int unsigned     wire_count = 0;
   int unsigned     fail_total = 0;
   wire_result_type pending_results [$];

   // append one bit to the store and return the index it landed on
   function automatic logic [WIRE_NUM_W-1:0] append_wire(input logic bit_in);
      logic [WIRE_NUM_W-1:0] idx;
      idx = wire_count[WIRE_NUM_W-1:0];
      wire_bits[wire_count] = bit_in;
      wire_count++;
      return idx;
   endfunction

   function automatic wire_result_type evaluate_line(
      input logic [1:0]            cmd,
      input logic                  value,
      input logic [1:0]            arity,
      input logic [WIRE_NUM_W-1:0] first,
      input logic [WIRE_NUM_W-1:0] second,
      input logic [TT_W-1:0]       tt
   );
      wire_result_type r;
      logic            bit_out;
      status_type      st;
      r.result_bit  = 1'b0;
      r.wire_number = '0;
      r.status      = ST_OK;
      bit_out       = 1'b0;
      st            = ST_OK;
      case (cmd)
         CMD_RESTART: begin
            wire_count = 0;
         end
         CMD_OUTPUT: begin
            r.wire_number = first;
            if (first < wire_count) begin
               r.result_bit = wire_bits[first];
            end else begin
               r.status = ST_UNWRITTEN;
            end
         end
         default: begin
            // a full store turns every append away, before any other check
            if (wire_count >= CAPACITY) begin
               r.status = ST_FULL;
            end else if (cmd == CMD_INPUT) begin
               r.result_bit  = value;
               r.wire_number = append_wire(value);
            end else begin
               if (arity != 2'd1 && arity != 2'd2) begin
                  st = ST_BAD_ARITY;
               end else if (first >= wire_count || (arity == 2'd2 && second >= wire_count)) begin
                  st = ST_UNWRITTEN;
               end else if (arity == 2'd2) begin
                  bit_out = tt[{wire_bits[first], wire_bits[second]}];
               end else begin
                  bit_out = tt[{1'b0, wire_bits[first]}];
               end
               r.result_bit  = bit_out;
               r.status      = st;
               r.wire_number = append_wire(bit_out);
            end
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin : watch
      wire_result_type want;
      if (reset) begin
         wire_count = 0;
         pending_results.delete();
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (pending_results.size() == 0) begin
               $error("unexpected response beat: result_bit %0b wire_number %0d status %0d",
                      rsp.result_bit, rsp.wire_number, rsp.status);
               fail_total++;
            end else begin
               want = pending_results.pop_front();
               if (rsp.result_bit !== want.result_bit) begin
                  $error("result_bit: expected %0b, actual %0b", want.result_bit, rsp.result_bit);
                  fail_total++;
               end
               if (rsp.wire_number !== want.wire_number) begin
                  $error("wire_number: expected %0d, actual %0d",
                         want.wire_number, rsp.wire_number);
                  fail_total++;
               end
               if (rsp.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp.status);
                  fail_total++;
               end
            end
         end
         if (req.valid && req.ready) begin
            pending_results = {pending_results,
                               evaluate_line(req.cmd, req.value, req.arity,
                                             req.first_wire, req.second_wire,
                                             req.truth_table)};
         end
      end
      mismatches  <= fail_total;
      outstanding <= pending_results.size();
   end

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Gate list evaluator testbench
// Drives directed gate lists and then random netlists, noise and broken
// lines, with bursty requests and a stalling receiver; the checker predicts
// and compares every response.
// ----------------------------------------------------------------------------
module testbench;
   import gle_pkg::*;

   localparam int unsigned CAPACITY     = WIRE_CAPACITY_DEF;
   localparam int unsigned RANDOM_LINES = 1220;
   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam logic [WIRE_NUM_W-1:0] TOP_WIRE = '1;

   typedef enum int unsigned {
      STALL_NONE,
      STALL_RANDOM,
      STALL_PATTERN,
      STALL_LONG
   } stall_mode_type;

   logic        clock;
   logic        reset;
   int unsigned mismatches;
   int unsigned outstanding;
   int unsigned built_wires = 0;
   int unsigned items_sent  = 0;
   int unsigned burst_left  = 0;
   int unsigned cycles      = 0;

   gle_req_if req_chan ();
   gle_rsp_if rsp_chan ();

   gate_list_circuit_evaluator_top uut (
      .clock (clock),
      .reset (reset),
      .req   (req_chan),
      .rsp   (rsp_chan)
   );

   netlist_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req         (req_chan),
      .rsp         (rsp_chan),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // present one line and hold it until the beat is taken
   task automatic send_line(
      input logic [1:0]            cmd,
      input logic                  value,
      input logic [1:0]            arity,
      input logic [WIRE_NUM_W-1:0] first,
      input logic [WIRE_NUM_W-1:0] second,
      input logic [TT_W-1:0]       tt
   );
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
         if (gap != 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_chan.valid       <= 1'b1;
      req_chan.cmd         <= cmd;
      req_chan.value       <= value;
      req_chan.arity       <= arity;
      req_chan.first_wire  <= first;
      req_chan.second_wire <= second;
      req_chan.truth_table <= tt;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      items_sent++;
      if (cmd == CMD_RESTART) begin
         built_wires = 0;
      end else if (cmd != CMD_OUTPUT && built_wires < CAPACITY) begin
         built_wires++;
      end
   endtask

   function automatic logic [WIRE_NUM_W-1:0] some_wire();
      if (built_wires == 0) begin
         return '0;
      end
      return WIRE_NUM_W'($urandom % built_wires);
   endfunction

   // receiver back-pressure
   initial begin : stall_gen
      stall_mode_type mode;
      int unsigned    hold_left;
      logic [7:0]     pattern;
      mode      = STALL_NONE;
      hold_left = 0;
      pattern   = '1;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left == 0) begin
            mode      = stall_mode_type'($urandom_range(0, 3));
            hold_left = $urandom_range(8, 120);
            pattern   = 8'($urandom);
         end
         hold_left--;
         case (mode)
            STALL_NONE:    rsp_chan.ready <= 1'b1;
            STALL_RANDOM:  rsp_chan.ready <= ($urandom_range(0, 3) != 0);
            STALL_PATTERN: begin
               rsp_chan.ready <= pattern[0];
               pattern = {pattern[0], pattern[7:1]};
            end
            default:       rsp_chan.ready <= ((hold_left % 16) < 6);
         endcase
      end
   end

   initial begin : watchdog
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("testbench: FAIL");
      $finish;
   end

   initial begin : stimulus
      int unsigned mark;
      int unsigned n_in;
      int unsigned n_gate;
      int unsigned pick;
      req_chan.valid       <= 1'b0;
      req_chan.cmd         <= CMD_RESTART;
      req_chan.value       <= 1'b0;
      req_chan.arity       <= 2'd0;
      req_chan.first_wire  <= '0;
      req_chan.second_wire <= '0;
      req_chan.truth_table <= '0;
      reset <= 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed lines
      send_line(CMD_RESTART, 1'b0, 2'd0, '0, '0, 4'h0);
      send_line(CMD_OUTPUT,  1'b0, 2'd0, '0, '0, 4'h0);
      send_line(CMD_GATE,    1'b0, 2'd2, '0, '0, 4'hF);
      send_line(CMD_INPUT,   1'b1, 2'd0, '0, '0, 4'h0);
      send_line(CMD_INPUT,   1'b0, 2'd0, '0, '0, 4'h0);
      // walk every truth table row
      send_line(CMD_GATE,    1'b0, 2'd2, 12'd1, 12'd1, 4'b1000);
      send_line(CMD_GATE,    1'b0, 2'd2, 12'd1, 12'd2, 4'b0100);
      send_line(CMD_GATE,    1'b0, 2'd2, 12'd2, 12'd1, 4'b0010);
      send_line(CMD_GATE,    1'b0, 2'd2, 12'd2, 12'd2, 4'b0001);
      send_line(CMD_GATE,    1'b0, 2'd1, 12'd1, TOP_WIRE, 4'b0010);
      send_line(CMD_GATE,    1'b0, 2'd1, 12'd2, '0, 4'b1110);
      // bad arity, then unwritten inputs on either port
      send_line(CMD_GATE,    1'b1, 2'd0, TOP_WIRE, TOP_WIRE, 4'hF);
      send_line(CMD_GATE,    1'b0, 2'd3, 12'd1, 12'd1, 4'hF);
      send_line(CMD_GATE,    1'b0, 2'd2, 12'd1, TOP_WIRE, 4'hF);
      send_line(CMD_GATE,    1'b0, 2'd2, TOP_WIRE, 12'd1, 4'hF);
      send_line(CMD_GATE,    1'b0, 2'd1, 12'd13, '0, 4'hF);
      send_line(CMD_OUTPUT,  1'b0, 2'd0, 12'd13, '0, 4'h0);
      send_line(CMD_OUTPUT,  1'b0, 2'd0, 12'd14, '0, 4'h0);
      send_line(CMD_OUTPUT,  1'b1, 2'd3, TOP_WIRE, TOP_WIRE, 4'hF);
      send_line(CMD_OUTPUT,  1'b0, 2'd0, 12'd7, '0, 4'h0);
      send_line(CMD_GATE,    1'b0, 2'd2, 12'd7, 12'd4, 4'h0);
      send_line(CMD_RESTART, 1'b1, 2'd3, TOP_WIRE, TOP_WIRE, 4'hF);
      send_line(CMD_OUTPUT,  1'b0, 2'd0, 12'd1, '0, 4'h0);
      send_line(CMD_INPUT,   1'b1, 2'd3, TOP_WIRE, TOP_WIRE, 4'hF);
      send_line(CMD_OUTPUT,  1'b0, 2'd0, '0, '0, 4'h0);

      // random netlists, mostly well formed
      mark = items_sent;
      while (items_sent - mark < RANDOM_LINES) begin
         pick = $urandom_range(0, 9);
         if (pick < 7) begin
            if ($urandom_range(0, 7) != 0) begin
               send_line(CMD_RESTART, 1'($urandom), 2'($urandom), 12'($urandom),
                         12'($urandom), 4'($urandom));
            end
            n_in = $urandom_range(1, 8);
            repeat (n_in) begin
               send_line(CMD_INPUT, 1'($urandom), 2'($urandom), 12'($urandom),
                         12'($urandom), 4'($urandom));
            end
            n_gate = $urandom_range(1, 30);
            repeat (n_gate) begin
               pick = $urandom_range(0, 9);
               if (pick < 7) begin
                  send_line(CMD_GATE, 1'($urandom), 2'($urandom_range(1, 2)), some_wire(),
                            some_wire(), 4'($urandom));
               end else if (pick < 9) begin
                  send_line(CMD_OUTPUT, 1'($urandom), 2'($urandom), some_wire(),
                            12'($urandom), 4'($urandom));
               end else begin
                  send_line(CMD_OUTPUT, 1'($urandom), 2'($urandom), 12'(built_wires),
                            12'($urandom), 4'($urandom));
               end
            end
         end else if (pick < 9) begin
            // noise: anything the fields allow
            repeat ($urandom_range(1, 6)) begin
               send_line(2'($urandom), 1'($urandom), 2'($urandom), 12'($urandom),
                         12'($urandom), 4'($urandom));
            end
         end else begin
            // broken lines: bad arity and references at the edge of the count
            repeat ($urandom_range(1, 6)) begin
               case ($urandom_range(0, 3))
                  0: send_line(CMD_GATE, 1'($urandom),
                               ($urandom_range(0, 1) != 0) ? 2'd3 : 2'd0,
                               12'($urandom), 12'($urandom), 4'($urandom));
                  1: send_line(CMD_GATE, 1'($urandom), 2'd2, some_wire(),
                               12'(built_wires), 4'($urandom));
                  2: send_line(CMD_GATE, 1'($urandom), 2'($urandom_range(1, 2)),
                               12'(built_wires), some_wire(), 4'($urandom));
                  default: send_line(CMD_OUTPUT, 1'($urandom), 2'($urandom),
                                     12'(built_wires), 12'($urandom), 4'($urandom));
               endcase
            end
         end
      end

      // drain, then allow a few more cycles for stray beats
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
